// ===== rtl/three_table_simple_hash_binning_defines.svh =====
// ----------------------------------------------------------------------------
// Three-table hash binning: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef THREE_TABLE_SIMPLE_HASH_BINNING_DEFINES_SVH
`define THREE_TABLE_SIMPLE_HASH_BINNING_DEFINES_SVH

// same-cycle implication
`define TTSHB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ttshb check failed");

// next-cycle implication
`define TTSHB_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ttshb check failed");

`endif

// ===== rtl/ttshb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-table hash binning package
// Payload types, control types and sizing constants.
// ----------------------------------------------------------------------------
package ttshb_pkg;

    localparam int TABLES          = 3;
    localparam int HASH_W          = 64;
    localparam int ITEM_INDEX_W    = 20;
    localparam int BIN_OUT_W       = 10;
    localparam int SLOT_OUT_W      = 5;
    localparam int PLACED_W        = 2;
    localparam int CFG_W           = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam int BINS_MAX_DEF    = 1024;
    localparam int BIN_DEPTH_DEF   = 32;
    localparam int INDEX_BITS_DEF  = 20;

    typedef struct packed {
        logic [ITEM_INDEX_W-1:0] item_index;
        logic [HASH_W-1:0]       hash_zero;
        logic [HASH_W-1:0]       hash_one;
        logic [HASH_W-1:0]       hash_two;
    } t_in_item;

    typedef struct packed {
        logic [BIN_OUT_W-1:0]  bin_zero;
        logic [BIN_OUT_W-1:0]  bin_one;
        logic [BIN_OUT_W-1:0]  bin_two;
        logic [SLOT_OUT_W-1:0] slot_zero;
        logic [SLOT_OUT_W-1:0] slot_one;
        logic [SLOT_OUT_W-1:0] slot_two;
        logic                  full_zero;
        logic                  full_one;
        logic                  full_two;
        logic [PLACED_W-1:0]   placed_count;
    } t_out_item;

    typedef struct packed {
        logic clr;
        logic rd;
        logic upd;
    } t_tbl_ctl;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_READ,
        S_UPDATE
    } t_state;

endpackage

// ===== rtl/ttshb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-lane serial remainder unit
// Reduces three 64-bit hashes modulo one divisor, one bit per cycle per lane.
// ----------------------------------------------------------------------------
module ttshb_div #(
    parameter int BINS_MAX = ttshb_pkg::BINS_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ttshb_pkg::HASH_W-1:0]  i_hash [ttshb_pkg::TABLES],
    input  logic [$clog2(BINS_MAX+1)-1:0] i_divisor,
    output logic                          o_done,
    output logic [$clog2(BINS_MAX+1)-1:0] o_rem [ttshb_pkg::TABLES]
);

    localparam int DIV_W = $clog2(BINS_MAX + 1);
    localparam int CNT_W = $clog2(ttshb_pkg::HASH_W);

    logic [ttshb_pkg::HASH_W-1:0] r_hash [ttshb_pkg::TABLES];
    logic [ttshb_pkg::HASH_W-1:0] n_hash [ttshb_pkg::TABLES];
    logic [DIV_W-1:0]             r_rem  [ttshb_pkg::TABLES];
    logic [DIV_W-1:0]             n_rem  [ttshb_pkg::TABLES];
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [DIV_W:0]               w_shift [ttshb_pkg::TABLES];

    always_comb begin
        for (int l = 0; l < ttshb_pkg::TABLES; l++) begin
            w_shift[l] = {r_rem[l], r_hash[l][ttshb_pkg::HASH_W-1]};
            if (w_shift[l] >= {1'b0, i_divisor}) begin
                n_rem[l] = DIV_W'(w_shift[l] - {1'b0, i_divisor});
            end else begin
                n_rem[l] = w_shift[l][DIV_W-1:0];
            end
            n_hash[l] = {r_hash[l][ttshb_pkg::HASH_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ttshb_pkg::HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < ttshb_pkg::TABLES; l++) begin
            if (i_start) begin
                r_hash[l] <= i_hash[l];
                r_rem[l]  <= '0;
            end else if (r_busy) begin
                r_hash[l] <= n_hash[l];
                r_rem[l]  <= n_rem[l];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/ttshb_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bin table
// Fill-count memory with read-modify-write and the stored-index memory.
// ----------------------------------------------------------------------------
module ttshb_table #(
    parameter int BINS_MAX   = ttshb_pkg::BINS_MAX_DEF,
    parameter int BIN_DEPTH  = ttshb_pkg::BIN_DEPTH_DEF,
    parameter int INDEX_BITS = ttshb_pkg::INDEX_BITS_DEF
) (
    input  logic                                  i_clk,
    input  ttshb_pkg::t_tbl_ctl                   i_ctl,
    input  logic [((BINS_MAX > 1) ? $clog2(BINS_MAX) : 1)-1:0] i_addr,
    input  logic [INDEX_BITS-1:0]                 i_index,
    output logic [ttshb_pkg::SLOT_OUT_W-1:0]      o_slot,
    output logic                                  o_full
);

    localparam int FILL_W  = $clog2(BIN_DEPTH + 1);
    localparam int ENTRIES = BINS_MAX * BIN_DEPTH;
    localparam int ENT_AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [FILL_W-1:0]     r_fill_mem  [BINS_MAX];
    logic [INDEX_BITS-1:0] r_entry_mem [ENTRIES];
    logic [FILL_W-1:0]     r_fill;
    logic                  w_full;
    logic [ENT_AW-1:0]     w_ent_addr;

    assign w_full     = (r_fill >= FILL_W'(BIN_DEPTH));
    assign w_ent_addr = ENT_AW'(i_addr * BIN_DEPTH) + ENT_AW'(r_fill);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_fill_mem[i_addr] <= '0;
        end else if (i_ctl.upd && !w_full) begin
            r_fill_mem[i_addr] <= r_fill + 1'b1;
        end
        if (i_ctl.rd) begin
            r_fill <= r_fill_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && !w_full) begin
            r_entry_mem[w_ent_addr] <= i_index;
        end
    end

    assign o_full = w_full;
    assign o_slot = w_full ? '0 : ttshb_pkg::SLOT_OUT_W'(r_fill);

endmodule

// ===== rtl/three_table_simple_hash_binning.sv =====
`timescale 1ns / 1ps
// Path from input transfer to result valid: a 64-step serial remainder (one bit per
// cycle per lane), a handoff, a fill-count read, then the write-back and output load.
// One item in flight: input is ready only in idle, and a stalled output holds it back.
// Reset: synchronous; bins_per_table returns to 1024, then a clearing pass over all
// BINS_MAX bins zeroes the fill counts with input not ready.
// ----------------------------------------------------------------------------
// Three-table hash binning top level
// Bins each item index into three tables by hash modulo bins_per_table (clamped to 1..BINS_MAX).
// ----------------------------------------------------------------------------
module three_table_simple_hash_binning #(
    parameter int BINS_MAX   = ttshb_pkg::BINS_MAX_DEF,
    parameter int BIN_DEPTH  = ttshb_pkg::BIN_DEPTH_DEF,
    parameter int INDEX_BITS = ttshb_pkg::INDEX_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ttshb_pkg::t_in_item            i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ttshb_pkg::t_out_item           o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ttshb_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int BIN_W = (BINS_MAX > 1) ? $clog2(BINS_MAX) : 1;
    localparam int DIV_W = $clog2(BINS_MAX + 1);

    ttshb_pkg::t_state              r_state;
    ttshb_pkg::t_state              n_state;
    logic [ttshb_pkg::CFG_W-1:0]    r_bins_per_table;
    logic [BIN_W-1:0]               r_clr_addr;
    logic [INDEX_BITS-1:0]          r_index;
    logic                           r_out_valid;
    ttshb_pkg::t_out_item           r_out_item;
    ttshb_pkg::t_out_item           n_out_item;

    logic [DIV_W-1:0]               w_divisor;
    logic [ttshb_pkg::HASH_W-1:0]   w_hash [ttshb_pkg::TABLES];
    logic [DIV_W-1:0]               w_rem  [ttshb_pkg::TABLES];
    logic [BIN_W-1:0]               w_bin  [ttshb_pkg::TABLES];
    logic [BIN_W-1:0]               w_addr [ttshb_pkg::TABLES];
    logic [ttshb_pkg::SLOT_OUT_W-1:0] w_slot [ttshb_pkg::TABLES];
    logic                           w_full [ttshb_pkg::TABLES];
    logic                           w_div_done;
    logic                           w_div_start;
    logic                           w_clr_last;
    logic                           w_out_free;
    logic                           w_out_load;
    ttshb_pkg::t_tbl_ctl            w_ctl;

    assign w_hash[0]  = i_in_item.hash_zero;
    assign w_hash[1]  = i_in_item.hash_one;
    assign w_hash[2]  = i_in_item.hash_two;
    assign w_clr_last = (r_clr_addr == BIN_W'(BINS_MAX - 1));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready = (r_state == ttshb_pkg::S_IDLE);

    always_comb begin
        if (r_bins_per_table == '0) begin
            w_divisor = DIV_W'(1);
        end else if (32'(r_bins_per_table) > BINS_MAX) begin
            w_divisor = DIV_W'(BINS_MAX);
        end else begin
            w_divisor = DIV_W'(r_bins_per_table);
        end
    end

    ttshb_div #(
        .BINS_MAX (BINS_MAX)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_hash    (w_hash),
        .i_divisor (w_divisor),
        .o_done    (w_div_done),
        .o_rem     (w_rem)
    );

    for (genvar t = 0; t < ttshb_pkg::TABLES; t++) begin : g_table
        assign w_bin[t] = BIN_W'(w_rem[t]);

        ttshb_table #(
            .BINS_MAX   (BINS_MAX),
            .BIN_DEPTH  (BIN_DEPTH),
            .INDEX_BITS (INDEX_BITS)
        ) u_table (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_addr  (w_addr[t]),
            .i_index (r_index),
            .o_slot  (w_slot[t]),
            .o_full  (w_full[t])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttshb_pkg::S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ttshb_pkg::S_IDLE;
                end
            end
            ttshb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ttshb_pkg::S_DIVIDE;
                end
            end
            ttshb_pkg::S_DIVIDE: begin
                if (w_div_done) begin
                    n_state = ttshb_pkg::S_READ;
                end
            end
            ttshb_pkg::S_READ: begin
                n_state = ttshb_pkg::S_UPDATE;
            end
            ttshb_pkg::S_UPDATE: begin
                if (w_out_free) begin
                    n_state = ttshb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttshb_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        w_ctl       = '0;
        for (int t = 0; t < ttshb_pkg::TABLES; t++) begin
            w_addr[t] = w_bin[t];
        end
        unique case (r_state)
            ttshb_pkg::S_CLEAR: begin
                w_ctl.clr = 1'b1;
                for (int t = 0; t < ttshb_pkg::TABLES; t++) begin
                    w_addr[t] = r_clr_addr;
                end
            end
            ttshb_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                w_div_start = i_in_valid;
            end
            ttshb_pkg::S_DIVIDE: begin
            end
            ttshb_pkg::S_READ: begin
                w_ctl.rd = 1'b1;
            end
            ttshb_pkg::S_UPDATE: begin
                w_ctl.upd  = w_out_free;
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_item              = '0;
        n_out_item.bin_zero     = ttshb_pkg::BIN_OUT_W'(w_bin[0]);
        n_out_item.bin_one      = ttshb_pkg::BIN_OUT_W'(w_bin[1]);
        n_out_item.bin_two      = ttshb_pkg::BIN_OUT_W'(w_bin[2]);
        n_out_item.slot_zero    = w_slot[0];
        n_out_item.slot_one     = w_slot[1];
        n_out_item.slot_two     = w_slot[2];
        n_out_item.full_zero    = w_full[0];
        n_out_item.full_one     = w_full[1];
        n_out_item.full_two     = w_full[2];
        n_out_item.placed_count = ttshb_pkg::PLACED_W'(!w_full[0])
                                + ttshb_pkg::PLACED_W'(!w_full[1])
                                + ttshb_pkg::PLACED_W'(!w_full[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ttshb_pkg::S_CLEAR;
            r_bins_per_table <= ttshb_pkg::CFG_RESET;
            r_clr_addr       <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bins_per_table <= i_cfg_data;
            end
            if (r_state == ttshb_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_index <= INDEX_BITS'(i_in_item.item_index);
        end
        if (w_out_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/ttshb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-table hash binning port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "three_table_simple_hash_binning_defines.svh"

module ttshb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input ttshb_pkg::t_in_item         i_in_item,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input ttshb_pkg::t_out_item        o_out_item,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready,
    input logic [ttshb_pkg::CFG_W-1:0] i_cfg_data
);

    `TTSHB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))
    `TTSHB_ASSERT_IMP(a_placed, i_clk, i_rst_n, o_out_valid, $countones({!o_out_item.full_zero, !o_out_item.full_one, !o_out_item.full_two}) == 32'(o_out_item.placed_count))
    `TTSHB_ASSERT_IMP(a_full_slot, i_clk, i_rst_n, o_out_valid, (!o_out_item.full_zero || o_out_item.slot_zero == '0) && (!o_out_item.full_one || o_out_item.slot_one == '0) && (!o_out_item.full_two || o_out_item.slot_two == '0))
    `TTSHB_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind three_table_simple_hash_binning ttshb_checker u_ttshb_checker (.*);
